@@ rtl/uihb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the UDP/IPv4 header builder.
package uihb_pkg;

  localparam int MAX_PAYLOAD = 1472;
  localparam int CNT_W       = 11;
  localparam int HDR_BYTES   = 42;
  localparam int HDR_W       = HDR_BYTES * 8;
  localparam int BEAT_W      = $clog2(HDR_BYTES);

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;

  localparam logic [2:0] REG_SOURCE_MAC = 3'd0;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [47:0] dest_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_udp_port;
    logic [15:0] dest_udp_port;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       end_of_header;
    logic       payload_overflow;
  } out_beat_t;

  // Packet totals handed from the byte accumulator to the checksum pipe.
  typedef struct packed {
    logic [31:0]      sum;
    logic [CNT_W-1:0] count;
    logic [7:0]       pending;
    logic [47:0]      dest_mac;
    logic [31:0]      source_ip;
    logic [31:0]      dest_ip;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic             overflow;
  } fin_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [15:0] ip_ck;
    logic [15:0] udp_ck;
    logic        overflow;
  } hdr_t;

  typedef struct packed {
    logic b_busy;
    logic c_busy;
    logic d_busy;
  } csum_stat_t;

endpackage

@@ rtl/udp_ipv4_header_builder.sv @@
`timescale 1ns / 1ps
// Top level of the UDP/IPv4/Ethernet header builder with configuration port.
// Takes one UDP payload byte per cycle and, after the byte marked last, sends
// the 42-byte Ethernet/IPv4/UDP header one byte per beat, checksums included.
// After a packet's last byte is taken, its header passes through the totals
// register and the three checksum stages; then the header shift register
// sends one byte per cycle while out_ready is high. Payload bytes of the next
// packet keep flowing while a header is sent; a last byte is held off only
// while an earlier packet is still in the totals register or the checksum
// stages. Payload beyond 1472 bytes is dropped and flagged on every byte of
// that packet's header. source_mac sits at byte address 0.
module udp_ipv4_header_builder import uihb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0] source_mac_r;
  logic        fin_valid;
  fin_t        fin;
  logic        hdr_valid;
  hdr_t        hdr;
  logic        take;
  csum_stat_t  stat;
  logic        pipe_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_mac_r <= '0;
    end else if (psel && penable && pwrite && (paddr == REG_SOURCE_MAC)) begin
      source_mac_r <= pwdata[47:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SOURCE_MAC) ? {16'b0, source_mac_r} : 64'b0;

  assign pipe_busy = fin_valid | stat.b_busy | stat.c_busy | stat.d_busy;
  assign in_ready  = !in_data.last_byte || !pipe_busy;

  uihb_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  uihb_csum u_csum (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin       (fin),
    .take      (take),
    .hdr_valid (hdr_valid),
    .hdr       (hdr),
    .stat      (stat)
  );

  uihb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .hdr_valid  (hdr_valid),
    .hdr        (hdr),
    .source_mac (source_mac_r),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // at most one packet's totals in flight ahead of the header register
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({fin_valid, stat.b_busy, stat.c_busy, stat.d_busy}))
    else $error("more than one packet in the checksum pipe");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.end_of_header && !hdr_valid) |=> !out_valid)
    else $error("header beats continue after the final beat");

  a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_valid && !out_valid) |=> (out_valid && !stat.d_busy))
    else $error("finished header not loaded into idle shifter");

endmodule

@@ rtl/uihb_accum.sv @@
`timescale 1ns / 1ps
// Payload byte counter, word sum and per-packet field capture.
module uihb_accum import uihb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_beat_t in_data,
  output logic     fin_valid,
  output fin_t     fin
);

  logic [31:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       pending_r, pending_nxt;
  logic             inside_r;
  logic             ovf_r, ovf_nxt;
  logic             fin_valid_r;
  fin_t             fin_r, fin_nxt;

  logic [47:0] dmac_r, dmac_lat;
  logic [31:0] sip_r, sip_lat;
  logic [31:0] dip_r, dip_lat;
  logic [15:0] sport_r, sport_lat;
  logic [15:0] dport_r, dport_lat;
  logic        take;

  always_comb begin
    take      = in_valid & in_ready;
    dmac_lat  = inside_r ? dmac_r  : in_data.dest_mac;
    sip_lat   = inside_r ? sip_r   : in_data.source_ip;
    dip_lat   = inside_r ? dip_r   : in_data.dest_ip;
    sport_lat = inside_r ? sport_r : in_data.source_udp_port;
    dport_lat = inside_r ? dport_r : in_data.dest_udp_port;

    acc_nxt     = acc_r;
    count_nxt   = count_r;
    pending_nxt = pending_r;
    ovf_nxt     = ovf_r;
    if (count_r < CNT_W'(MAX_PAYLOAD)) begin
      if (!count_r[0]) begin
        pending_nxt = in_data.payload_byte;
      end else begin
        acc_nxt = acc_r + {16'b0, pending_r, in_data.payload_byte};
      end
      count_nxt = count_r + 1'b1;
    end else begin
      ovf_nxt = 1'b1;
    end

    fin_nxt.sum         = acc_nxt;
    fin_nxt.count       = count_nxt;
    fin_nxt.pending     = pending_nxt;
    fin_nxt.dest_mac    = dmac_lat;
    fin_nxt.source_ip   = sip_lat;
    fin_nxt.dest_ip     = dip_lat;
    fin_nxt.source_port = sport_lat;
    fin_nxt.dest_port   = dport_lat;
    fin_nxt.overflow    = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      count_r     <= '0;
      pending_r   <= '0;
      inside_r    <= 1'b0;
      ovf_r       <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= take & in_data.last_byte;
      if (take) begin
        if (in_data.last_byte) begin
          acc_r     <= '0;
          count_r   <= '0;
          pending_r <= '0;
          inside_r  <= 1'b0;
          ovf_r     <= 1'b0;
        end else begin
          acc_r     <= acc_nxt;
          count_r   <= count_nxt;
          pending_r <= pending_nxt;
          inside_r  <= 1'b1;
          ovf_r     <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dmac_r  <= dmac_lat;
      sip_r   <= sip_lat;
      dip_r   <= dip_lat;
      sport_r <= sport_lat;
      dport_r <= dport_lat;
      if (in_data.last_byte) begin
        fin_r <= fin_nxt;
      end
    end
  end

  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

endmodule

@@ rtl/uihb_csum.sv @@
`timescale 1ns / 1ps
// Three-stage pipe that forms the IPv4 and UDP checksums and lengths.
module uihb_csum import uihb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fin_valid,
  input  fin_t       fin,
  input  logic       take,
  output logic       hdr_valid,
  output hdr_t       hdr,
  output csum_stat_t stat
);

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = 17'(s[15:0]) + 17'(s[31:16]);
    u = 17'(t[15:0]) + 17'(t[16]);
    return u[15:0];
  endfunction

  logic        b_v_r, c_v_r, d_v_r;
  hdr_t        b_hdr_r, c_hdr_r, d_hdr_r;
  logic [31:0] b_sum_r;
  logic [17:0] b_addr_r;
  logic [18:0] b_pl_r;
  logic [18:0] c_ip_raw_r;
  logic [31:0] c_udp_raw_r;

  hdr_t        b_hdr_nxt, d_hdr_nxt;
  logic [31:0] b_sum_nxt;
  logic [17:0] b_addr_nxt;
  logic [18:0] b_pl_nxt;
  logic [18:0] c_ip_raw_nxt;
  logic [31:0] c_udp_raw_nxt;
  logic [15:0] udp_ck_raw;

  always_comb begin
    b_hdr_nxt.dest_mac    = fin.dest_mac;
    b_hdr_nxt.source_ip   = fin.source_ip;
    b_hdr_nxt.dest_ip     = fin.dest_ip;
    b_hdr_nxt.source_port = fin.source_port;
    b_hdr_nxt.dest_port   = fin.dest_port;
    b_hdr_nxt.ip_len      = 16'(fin.count) + IP_UDP_HDR_LEN;
    b_hdr_nxt.udp_len     = 16'(fin.count) + UDP_HDR_LEN;
    b_hdr_nxt.ip_ck       = '0;
    b_hdr_nxt.udp_ck      = '0;
    b_hdr_nxt.overflow    = fin.overflow;

    // odd byte count: last byte padded with a zero low byte
    b_sum_nxt  = fin.sum + (fin.count[0] ? {16'b0, fin.pending, 8'b0} : 32'b0);
    b_addr_nxt = 18'(fin.source_ip[31:16]) + 18'(fin.source_ip[15:0])
               + 18'(fin.dest_ip[31:16]) + 18'(fin.dest_ip[15:0]);
    b_pl_nxt   = 19'(fin.source_port) + 19'(fin.dest_port)
               + 19'({b_hdr_nxt.udp_len, 1'b0}) + 19'(IP_PROTO_UDP);

    c_ip_raw_nxt  = 19'({IP_VER_IHL, 8'h00}) + 19'({IP_TTL, IP_PROTO_UDP})
                  + 19'(b_hdr_r.ip_len) + 19'(b_addr_r);
    c_udp_raw_nxt = b_sum_r + 32'(b_addr_r) + 32'(b_pl_r);

    d_hdr_nxt       = c_hdr_r;
    d_hdr_nxt.ip_ck = ~ones_fold(32'(c_ip_raw_r));
    udp_ck_raw      = ~ones_fold(c_udp_raw_r);
    d_hdr_nxt.udp_ck = (udp_ck_raw == 16'h0000) ? 16'hFFFF : udp_ck_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      b_v_r <= fin_valid;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r | (d_v_r & ~take);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid) begin
      b_hdr_r  <= b_hdr_nxt;
      b_sum_r  <= b_sum_nxt;
      b_addr_r <= b_addr_nxt;
      b_pl_r   <= b_pl_nxt;
    end
    if (b_v_r) begin
      c_hdr_r     <= b_hdr_r;
      c_ip_raw_r  <= c_ip_raw_nxt;
      c_udp_raw_r <= c_udp_raw_nxt;
    end
    if (c_v_r) begin
      d_hdr_r <= d_hdr_nxt;
    end
  end

  assign hdr_valid   = d_v_r;
  assign hdr         = d_hdr_r;
  assign stat.b_busy = b_v_r;
  assign stat.c_busy = c_v_r;
  assign stat.d_busy = d_v_r;

endmodule

@@ rtl/uihb_emit.sv @@
`timescale 1ns / 1ps
// Header shift register that sends the 42 header bytes, one per beat.
module uihb_emit import uihb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hdr_valid,
  input  hdr_t        hdr,
  input  logic [47:0] source_mac,
  output logic        take,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data
);

  logic [HDR_W-1:0]  shift_r, hdr_vec;
  logic [BEAT_W-1:0] beat_r;
  logic              busy_r;
  logic              ovf_r;
  logic              last_beat;
  logic              load_ok;

  always_comb begin
    last_beat = (beat_r == BEAT_W'(HDR_BYTES - 1));
    load_ok   = !busy_r || (out_ready && last_beat);
    take      = hdr_valid & load_ok;
    hdr_vec   = {hdr.dest_mac, source_mac, ETH_TYPE_IPV4,
                 IP_VER_IHL, 8'h00, hdr.ip_len, 16'h0000, 16'h0000,
                 IP_TTL, IP_PROTO_UDP, hdr.ip_ck,
                 hdr.source_ip, hdr.dest_ip,
                 hdr.source_port, hdr.dest_port, hdr.udp_len, hdr.udp_ck};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= '0;
    end else if (take) begin
      busy_r <= 1'b1;
      beat_r <= '0;
    end else if (busy_r && out_ready) begin
      beat_r <= beat_r + 1'b1;
      if (last_beat) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      shift_r <= hdr_vec;
      ovf_r   <= hdr.overflow;
    end else if (busy_r && out_ready) begin
      shift_r <= {shift_r[HDR_W-9:0], 8'h00};
    end
  end

  assign out_valid                 = busy_r;
  assign out_data.header_byte      = shift_r[HDR_W-1 -: 8];
  assign out_data.end_of_header    = last_beat;
  assign out_data.payload_overflow = ovf_r;

endmodule
